// ===== rtl/tcm_pkg.sv =====
// Shared types and constants for the terrace curve mapper.
// No dependencies; imported by every module in rtl/.
`default_nettype none

package tcm_pkg;

  // Fixed alpha format: unsigned Q0.16, with 1.0 held in 17 bits.
  localparam int ALPHA_BITS = 16;
  localparam logic [ALPHA_BITS:0] ALPHA_ONE = 17'h10000;
  localparam logic [ALPHA_BITS:0] ALPHA_MAX = 17'h0ffff;

  // The divider resolves this many quotient bits per pipeline stage.
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_STAGES = ALPHA_BITS / DIV_STEP_BITS;

  // Configuration register map.
  localparam int CFG_IDX_W = 3;
  localparam int PCOUNT_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_A = 3'd2;

  localparam logic [PCOUNT_W-1:0] POINT_COUNT_RESET = 3'd2;
  localparam logic signed [31:0] POINT_A_RESET = -32'sd4096;
  localparam logic signed [31:0] POINT_B_RESET = 32'sd4096;

  // Control flags that travel with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic too_few;
    logic direct;
    logic alpha_zero;
    logic alpha_sat;
  } tcm_ctl_t;

endpackage : tcm_pkg

`default_nettype wire

// ===== rtl/tcm_select.sv =====
// Front end of the mapper: bracketing-point search and offset/span classify.
// Two register stages. Depends on tcm_pkg.
`default_nettype none

module tcm_select
  import tcm_pkg::*;
#(
  parameter int W = 16,
  parameter int MAX_POINTS = 6,
  parameter int CNT_W = 3
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic signed [W-1:0] src,
  input  wire logic [CNT_W-1:0]    count_sat,
  input  wire logic signed [W-1:0] pts [MAX_POINTS],
  output tcm_ctl_t                 ctl_o,
  output logic [W-1:0]             rem_o,
  output logic [W-1:0]             span_o,
  output logic signed [W-1:0]      v0_o,
  output logic signed [W-1:0]      v1_o
);

  localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  logic [MAX_POINTS-1:0] lt;
  logic [CNT_W-1:0]      pos;
  logic [CNT_W-1:0]      i0;
  logic [CNT_W-1:0]      i1;
  tcm_ctl_t              ctl1_nxt;
  tcm_ctl_t              ctl1_r;
  logic signed [W-1:0]   src1_r;
  logic signed [W-1:0]   v0_1_r;
  logic signed [W-1:0]   v1_1_r;

  logic signed [W:0]     off2;
  logic signed [W:0]     span2;
  tcm_ctl_t              ctl2_nxt;
  tcm_ctl_t              ctl2_r;
  logic [W-1:0]          rem2_r;
  logic [W-1:0]          span2_r;
  logic signed [W-1:0]   v0_2_r;
  logic signed [W-1:0]   v1_2_r;

  // Stage 1: first point above the sample, then the pair around it.
  // With no points in use both indexes stay at zero so the read is in range.
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      lt[i] = (CNT_W'(i) < count_sat) && (src < pts[i]);
    end
    pos = count_sat;
    for (int i = MAX_POINTS - 1; i >= 0; i--) begin
      if (lt[i]) begin
        pos = CNT_W'(i);
      end
    end
    i0 = (pos == '0) ? '0 : pos - CNT_W'(1);
    i1 = (pos == count_sat && count_sat != '0) ? count_sat - CNT_W'(1) : pos;
    ctl1_nxt.valid      = in_vld;
    ctl1_nxt.too_few    = count_sat < CNT_W'(2);
    ctl1_nxt.direct     = (i0 == i1);
    ctl1_nxt.alpha_zero = 1'b0;
    ctl1_nxt.alpha_sat  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src1_r <= src;
      v0_1_r <= pts[i0[IDX_W-1:0]];
      v1_1_r <= pts[i1[IDX_W-1:0]];
    end
  end

  // Stage 2: offset and span. Unsorted or repeated points or a negative
  // offset give alpha zero; an offset at or past the span saturates alpha.
  always_comb begin
    off2  = $signed({src1_r[W-1], src1_r}) - $signed({v0_1_r[W-1], v0_1_r});
    span2 = $signed({v1_1_r[W-1], v1_1_r}) - $signed({v0_1_r[W-1], v0_1_r});
    ctl2_nxt            = ctl1_r;
    ctl2_nxt.alpha_zero = (span2 <= 0) || (off2 < 0);
    ctl2_nxt.alpha_sat  = !ctl2_nxt.alpha_zero && (off2 >= span2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem2_r  <= off2[W-1:0];
      span2_r <= span2[W-1:0];
      v0_2_r  <= v0_1_r;
      v1_2_r  <= v1_1_r;
    end
  end

  assign ctl_o  = ctl2_r;
  assign rem_o  = rem2_r;
  assign span_o = span2_r;
  assign v0_o   = v0_2_r;
  assign v1_o   = v1_2_r;

endmodule : tcm_select

`default_nettype wire

// ===== rtl/tcm_div_stage.sv =====
// One stage of the pipelined restoring divider that forms alpha.
// Resolves DIV_STEP_BITS quotient bits per stage. Depends on tcm_pkg.
`default_nettype none

module tcm_div_stage
  import tcm_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire tcm_ctl_t             ctl_i,
  input  wire logic [W-1:0]         rem_i,
  input  wire logic [ALPHA_BITS-1:0] quo_i,
  input  wire logic [W-1:0]         span_i,
  input  wire logic signed [W-1:0]  v0_i,
  input  wire logic signed [W-1:0]  v1_i,
  output tcm_ctl_t                  ctl_o,
  output logic [W-1:0]              rem_o,
  output logic [ALPHA_BITS-1:0]     quo_o,
  output logic [W-1:0]              span_o,
  output logic signed [W-1:0]       v0_o,
  output logic signed [W-1:0]       v1_o
);

  logic [W:0]            dbl;
  logic [W-1:0]          rem_nxt;
  logic [ALPHA_BITS-1:0] quo_nxt;
  tcm_ctl_t              ctl_r;
  logic [W-1:0]          rem_r;
  logic [ALPHA_BITS-1:0] quo_r;
  logic [W-1:0]          span_r;
  logic signed [W-1:0]   v0_r;
  logic signed [W-1:0]   v1_r;

  // The remainder stays below the span, so the doubled value fits W+1 bits.
  always_comb begin
    dbl     = '0;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    for (int s = 0; s < DIV_STEP_BITS; s++) begin
      dbl = {rem_nxt, 1'b0};
      if (dbl >= {1'b0, span_i}) begin
        rem_nxt = W'(dbl - {1'b0, span_i});
        quo_nxt = {quo_nxt[ALPHA_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = dbl[W-1:0];
        quo_nxt = {quo_nxt[ALPHA_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      span_r <= span_i;
      v0_r   <= v0_i;
      v1_r   <= v1_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign quo_o  = quo_r;
  assign span_o = span_r;
  assign v0_o   = v0_r;
  assign v1_o   = v1_r;

endmodule : tcm_div_stage

`default_nettype wire

// ===== rtl/tcm_interp.sv =====
// Back end of the mapper: alpha select and inversion, squaring, and the
// linear blend into the output register. Four stages. Depends on tcm_pkg.
`default_nettype none

module tcm_interp
  import tcm_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  invert,
  input  wire tcm_ctl_t              ctl_i,
  input  wire logic [ALPHA_BITS-1:0] quo_i,
  input  wire logic signed [W-1:0]   v0_i,
  input  wire logic signed [W-1:0]   v1_i,
  output logic                       out_vld,
  output logic signed [W-1:0]        out_val,
  output logic                       out_few
);

  logic [ALPHA_BITS:0]     alpha_nxt;
  logic signed [W-1:0]     base_nxt;
  logic signed [W:0]       delta_nxt;
  tcm_ctl_t                ctla_r;
  logic [ALPHA_BITS:0]     alpha_r;
  logic signed [W-1:0]     basea_r;
  logic signed [W:0]       deltaa_r;

  logic [2*ALPHA_BITS+1:0] sq;
  tcm_ctl_t                ctlb_r;
  logic [ALPHA_BITS:0]     a2_r;
  logic signed [W-1:0]     baseb_r;
  logic signed [W:0]       deltab_r;

  logic signed [W+18:0]    prod_nxt;
  tcm_ctl_t                ctlc_r;
  logic signed [W+18:0]    prod_r;
  logic signed [W-1:0]     basec_r;

  logic signed [W-1:0]     res_nxt;
  logic                    vld_r;
  logic                    few_r;
  logic signed [W-1:0]     res_r;

  // Stage A. For a direct item the base carries the upper point itself.
  always_comb begin
    if (ctl_i.alpha_zero) begin
      alpha_nxt = '0;
    end else if (ctl_i.alpha_sat) begin
      alpha_nxt = ALPHA_MAX;
    end else begin
      alpha_nxt = {1'b0, quo_i};
    end
    if (invert) begin
      alpha_nxt = ALPHA_ONE - alpha_nxt;
      delta_nxt = $signed({v0_i[W-1], v0_i}) - $signed({v1_i[W-1], v1_i});
    end else begin
      delta_nxt = $signed({v1_i[W-1], v1_i}) - $signed({v0_i[W-1], v0_i});
    end
    base_nxt = (invert || ctl_i.direct) ? v1_i : v0_i;
  end

  // Stage B: square of alpha, truncated back to Q0.16 (1.0 still fits).
  assign sq = alpha_r * alpha_r;

  // Stage C: signed span times the squared alpha.
  assign prod_nxt = deltab_r * $signed({1'b0, a2_r});

  // Stage D: the arithmetic shift floors the quotient by 65536.
  always_comb begin
    if (ctlc_r.too_few) begin
      res_nxt = '0;
    end else if (ctlc_r.direct) begin
      res_nxt = basec_r;
    end else begin
      res_nxt = basec_r + prod_r[W+15:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctla_r <= '0;
      ctlb_r <= '0;
      ctlc_r <= '0;
      vld_r  <= 1'b0;
    end else if (en) begin
      ctla_r <= ctl_i;
      ctlb_r <= ctla_r;
      ctlc_r <= ctlb_r;
      vld_r  <= ctlc_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r  <= alpha_nxt;
      basea_r  <= base_nxt;
      deltaa_r <= delta_nxt;
      a2_r     <= sq[2*ALPHA_BITS:ALPHA_BITS];
      baseb_r  <= basea_r;
      deltab_r <= deltaa_r;
      prod_r   <= prod_nxt;
      basec_r  <= baseb_r;
      res_r    <= res_nxt;
      few_r    <= ctlc_r.too_few;
    end
  end

  assign out_vld = vld_r;
  assign out_val = res_r;
  assign out_few = few_r;

endmodule : tcm_interp

`default_nettype wire

// ===== rtl/terrace_curve_mapper_unit.sv =====
// Terrace curve mapper top level: configuration registers and pipeline.
// Depends on tcm_pkg, tcm_select, tcm_div_stage and tcm_interp.
//
// Usage: each item on the input channel is one signed Q4.12 sample on
// in_source_value, taken when in_valid is high and in_stall is low. Each
// item yields exactly one result item on the output channel: the mapped
// sample on out_terraced_value and the flag out_too_few_points, offered
// with out_valid and taken when out_stall is low.
// From acceptance to out_valid an item passes two stages of point
// search and classify, eight divider stages at two quotient bits each,
// then alpha select, squaring, blend multiply and the output register.
// Throughput is one item per cycle while no stall holds the pipeline; the divider pipeline sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is lost.
// The configuration port writes point_count (index 0), invert_terraces
// (index 1) and the control points (indexes 2 to 7). The user must write
// them only while the pipeline is empty; the block does not enforce it.
// Reset empties the pipeline and restores points -1.0 and +1.0, no inversion.
`default_nettype none

module terrace_curve_mapper_unit
  import tcm_pkg::*;
#(
  parameter int MAX_POINTS = 6,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]        cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_source_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0]      out_terraced_value,
  output logic                               out_too_few_points
);

  localparam int W = SAMPLE_BITS;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  logic [PCOUNT_W-1:0]   point_count_r;
  logic                  invert_r;
  logic signed [W-1:0]   pts_r [MAX_POINTS];
  logic [CNT_W-1:0]      count_sat;
  logic                  en;

  tcm_ctl_t              ctl_d  [DIV_STAGES+1];
  logic [W-1:0]          rem_d  [DIV_STAGES+1];
  logic [ALPHA_BITS-1:0] quo_d  [DIV_STAGES+1];
  logic [W-1:0]          span_d [DIV_STAGES+1];
  logic signed [W-1:0]   v0_d   [DIV_STAGES+1];
  logic signed [W-1:0]   v1_d   [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= POINT_COUNT_RESET;
      invert_r      <= 1'b0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (i == 0) begin
          pts_r[i] <= POINT_A_RESET[W-1:0];
        end else if (i == 1) begin
          pts_r[i] <= POINT_B_RESET[W-1:0];
        end else begin
          pts_r[i] <= '0;
        end
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_POINT_COUNT) begin
        point_count_r <= cfg_data[PCOUNT_W-1:0];
      end else if (cfg_index == REG_INVERT) begin
        invert_r <= cfg_data[0];
      end else begin
        // Points beyond the supported count are never read, so not stored.
        for (int i = 0; i < MAX_POINTS; i++) begin
          if (cfg_index == REG_POINT_A + CFG_IDX_W'(i)) begin
            pts_r[i] <= cfg_data;
          end
        end
      end
    end
  end

  assign count_sat = (point_count_r > PCOUNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                             : CNT_W'(point_count_r);

  // The pipeline moves as one unless a finished item waits at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  tcm_select #(
    .W          (W),
    .MAX_POINTS (MAX_POINTS),
    .CNT_W      (CNT_W)
  ) u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_valid),
    .src       (in_source_value),
    .count_sat (count_sat),
    .pts       (pts_r),
    .ctl_o     (ctl_d[0]),
    .rem_o     (rem_d[0]),
    .span_o    (span_d[0]),
    .v0_o      (v0_d[0]),
    .v1_o      (v1_d[0])
  );

  assign quo_d[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    tcm_div_stage #(
      .W (W)
    ) u_div (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_d[g]),
      .rem_i  (rem_d[g]),
      .quo_i  (quo_d[g]),
      .span_i (span_d[g]),
      .v0_i   (v0_d[g]),
      .v1_i   (v1_d[g]),
      .ctl_o  (ctl_d[g+1]),
      .rem_o  (rem_d[g+1]),
      .quo_o  (quo_d[g+1]),
      .span_o (span_d[g+1]),
      .v0_o   (v0_d[g+1]),
      .v1_o   (v1_d[g+1])
    );
  end

  tcm_interp #(
    .W (W)
  ) u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .invert  (invert_r),
    .ctl_i   (ctl_d[DIV_STAGES]),
    .quo_i   (quo_d[DIV_STAGES]),
    .v0_i    (v0_d[DIV_STAGES]),
    .v1_i    (v1_d[DIV_STAGES]),
    .out_vld (out_valid),
    .out_val (out_terraced_value),
    .out_few (out_too_few_points)
  );

  // An item flagged for too few points carries a zero value.
  a_few_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_few_points |-> out_terraced_value == '0)
    else $error("too_few_points item with nonzero value");

  // The user, not the block, must keep configuration static while items are in flight, so the flag agrees.
  a_few_cfg : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_too_few_points == (count_sat < CNT_W'(2)))
    else $error("too_few_points disagrees with point count");

  // Classify never marks an item both zero and saturated.
  a_alpha_cls : assert property (@(posedge clk) disable iff (!rst_n)
    ctl_d[0].valid |-> !(ctl_d[0].alpha_zero && ctl_d[0].alpha_sat))
    else $error("alpha both zero and saturated");

  // Reset empties the output register.
  a_rst_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule : terrace_curve_mapper_unit

`default_nettype wire

// ===== tb/terrace_map_checker.sv =====
`timescale 1ns / 100ps
// Checker for the terrace curve mapper: follows the configuration port, predicts each
// mapped sample and compares it with the result channel. Depends on tcm_pkg.
module terrace_map_checker
  import tcm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic signed [15:0]   in_source_value,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic signed [15:0]   out_terraced_value,
  input  wire logic                 out_too_few_points,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int MAX_PTS = 6;
  localparam longint UNIT = 65536;

  typedef struct packed {
    logic signed [15:0] source;
    logic signed [15:0] value;
    logic               too_few;
  } terrace_map_t;

  // Local copy of the curve registers.
  logic [PCOUNT_W-1:0] pt_count;
  logic                invert_on;
  logic signed [15:0]  ctrl_pt [MAX_PTS];

  terrace_map_t expected_maps [$];
  terrace_map_t want;

  function automatic terrace_map_t map_through_terraces(input logic signed [15:0] src);
    terrace_map_t r;
    longint       pt [MAX_PTS];
    longint       v0, v1, off, span, alpha, a2, t;
    int           cnt, pos, lo, hi;
    r.source = src;
    r.value = '0;
    r.too_few = 1'b0;
    cnt = int'(pt_count);
    if (cnt > MAX_PTS) cnt = MAX_PTS;
    if (cnt < 2) begin
      r.too_few = 1'b1;
      return r;
    end
    for (int i = 0; i < MAX_PTS; i++) pt[i] = ctrl_pt[i];
    // The first point above the sample closes the bracket.
    pos = 0;
    while (pos < cnt && !(longint'(src) < pt[pos])) pos++;
    lo = (pos - 1 < 0) ? 0 : pos - 1;
    hi = (pos > cnt - 1) ? cnt - 1 : pos;
    if (lo == hi) begin
      r.value = 16'(pt[hi]);
      return r;
    end
    v0 = pt[lo];
    v1 = pt[hi];
    off = longint'(src) - v0;
    span = v1 - v0;
    if (span <= 0 || off < 0) alpha = 0;
    else if (off >= span) alpha = UNIT - 1;
    else alpha = (off <<< 16) / span;
    if (invert_on) begin
      t = v0;
      alpha = UNIT - alpha;
      v0 = v1;
      v1 = t;
    end
    a2 = (alpha * alpha) >>> 16;
    // Arithmetic shift of a signed product rounds toward minus infinity.
    r.value = 16'(v0 + (((v1 - v0) * a2) >>> 16));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val,
                                 input int src);
    if (mismatches < 100)
      $display("%0t ns: %s: got %0d, expected %0d, source %0d", $time, what, got, exp_val,
               src);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pt_count = POINT_COUNT_RESET;
      invert_on = 1'b0;
      ctrl_pt[0] = 16'(POINT_A_RESET);
      ctrl_pt[1] = 16'(POINT_B_RESET);
      for (int i = 2; i < MAX_PTS; i++) ctrl_pt[i] = '0;
      expected_maps.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_maps.size() == 0) begin
          report_mismatch("result item with nothing expected", int'(out_terraced_value),
                          0, 0);
        end else begin
          want = expected_maps.pop_front();
          if (out_terraced_value !== want.value)
            report_mismatch("terraced_value", int'(out_terraced_value), int'(want.value),
                            int'(want.source));
          if (out_too_few_points !== want.too_few)
            report_mismatch("too_few_points", int'(out_too_few_points), int'(want.too_few),
                            int'(want.source));
        end
      end
      // Items are predicted with the curve in force before any write at this edge.
      if (in_valid && !in_stall)
        expected_maps.push_back(map_through_terraces(in_source_value));
      if (cfg_wr_en) begin
        if (cfg_index == REG_POINT_COUNT) pt_count = cfg_data[PCOUNT_W-1:0];
        else if (cfg_index == REG_INVERT) invert_on = cfg_data[0];
        else if (cfg_index >= REG_POINT_A) ctrl_pt[cfg_index - REG_POINT_A] = cfg_data;
      end
    end
    outstanding = expected_maps.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the terrace curve mapper testbench: clock, reset, curve programming, sample
// stimulus and receiver stalls. Depends on tcm_pkg, the mapper RTL and terrace_map_checker.
module tb;
  import tcm_pkg::*;

  localparam int DRAIN_CYCLES = 30;
  localparam int HOLD_CYCLES = 200;
  localparam int RANDOM_PHASES = 16;
  localparam int PHASE_ITEMS = 120;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [15:0]   in_source_value;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [15:0]   out_terraced_value;
  logic                 out_too_few_points;
  int                   errors;
  int                   pending;

  // Curve the stimulus is about to program.
  logic [2:0]           curve_count;
  logic                 curve_inv;
  logic signed [15:0]   curve_pt [6];

  bit gaps_on;
  bit stall_on;
  bit hold_off;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  terrace_curve_mapper_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_value    (in_source_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_terraced_value (out_terraced_value),
    .out_too_few_points (out_too_few_points)
  );

  terrace_map_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_source_value    (in_source_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_terraced_value (out_terraced_value),
    .out_too_few_points (out_too_few_points),
    .mismatches         (errors),
    .outstanding        (pending)
  );

  // Offer one sample and return once it has been taken. The stall is sampled at the
  // falling edge, where nothing changes until the next rising edge.
  task automatic send_sample(input logic signed [15:0] v);
    logic stalled;
    if (gaps_on)
      while ($urandom_range(99) < 20) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_source_value <= v;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_curve();
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data <= 16'(curve_count);
    @(posedge clk);
    cfg_index <= REG_INVERT;
    cfg_data <= 16'(curve_inv);
    @(posedge clk);
    for (int k = 0; k < 6; k++) begin
      cfg_index <= REG_POINT_A + CFG_IDX_W'(k);
      cfg_data <= curve_pt[k];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_curve(input logic [2:0] count, input logic inv,
                           input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic signed [15:0] c, input logic signed [15:0] d,
                           input logic signed [15:0] e, input logic signed [15:0] f);
    curve_count = count;
    curve_inv = inv;
    curve_pt[0] = a;
    curve_pt[1] = b;
    curve_pt[2] = c;
    curve_pt[3] = d;
    curve_pt[4] = e;
    curve_pt[5] = f;
  endtask

  // Mostly ascending unique points clustered at a random place and spread; some curves
  // are fully random, some span the whole range.
  task automatic pick_random_curve();
    int mode, base, spread, val, tmp;
    int vals [6];
    mode = $urandom_range(9);
    curve_inv = 1'($urandom_range(1));
    if (mode == 0) curve_count = 3'($urandom_range(1));
    else if (mode == 8) curve_count = 3'($urandom_range(6, 7));
    else curve_count = 3'($urandom_range(2, 7));
    base = int'($urandom_range(65535)) - 32768;
    spread = 1 << $urandom_range(4, 16);
    for (int k = 0; k < 6; k++) begin
      val = base + int'($urandom_range(spread)) - spread / 2;
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      vals[k] = val;
    end
    for (int k = 1; k < 6; k++)
      for (int j = k; j > 0 && vals[j] < vals[j-1]; j--) begin
        tmp = vals[j];
        vals[j] = vals[j-1];
        vals[j-1] = tmp;
      end
    // Nudging duplicates up can wrap at the top, which leaves the odd unsorted curve.
    for (int k = 1; k < 6; k++)
      if (vals[k] <= vals[k-1]) vals[k] = vals[k-1] + 1;
    if (mode == 8) begin
      vals[0] = -32768;
      vals[5] = 32767;
    end
    for (int k = 0; k < 6; k++)
      curve_pt[k] = (mode == 7) ? 16'($urandom) : 16'(vals[k]);
  endtask

  // Samples mostly land inside a bracket of the active curve, some on or next to a
  // point, the rest anywhere in range.
  function automatic logic signed [15:0] pick_source();
    int used, k, lo, hi, mode;
    used = (curve_count > 6) ? 6 : int'(curve_count);
    mode = $urandom_range(9);
    if (used < 2 || mode < 2) return 16'($urandom);
    if (mode == 2) return curve_pt[$urandom_range(used - 1)] + 16'($urandom_range(2)) - 16'd1;
    k = $urandom_range(used - 2);
    lo = curve_pt[k];
    hi = curve_pt[k+1];
    if (hi > lo) return 16'(lo + int'($urandom_range(hi - lo)));
    return 16'($urandom);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request so that the pipeline
  // fills and pushes back on the sender.
  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end else begin
        out_stall <= stall_on && ($urandom_range(99) < 20);
      end
    end
  end

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_source_value = '0;
    gaps_on = 1'b1;
    stall_on = 1'b1;
    hold_off = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Curve left by reset: two points at -1.0 and +1.0.
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd4096);
    send_sample(-16'sd4097);
    send_sample(16'sd4096);
    send_sample(16'sd4095);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    drain_pipeline();

    // Too few points, none and one.
    set_curve(3'd0, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    program_curve();
    send_sample(16'sd0);
    send_sample(16'sh7fff);
    drain_pipeline();
    set_curve(3'd1, 1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    program_curve();
    send_sample(-16'sd5);
    drain_pipeline();

    // Count above the limit, inverted, points at both ends of the range.
    set_curve(3'd7, 1'b1, 16'sh8000, -16'sd16384, -16'sd1, 16'sd0, 16'sd16384, 16'sh7fff);
    program_curve();
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(-16'sd20000);
    send_sample(-16'sd1);
    send_sample(16'sd10000);
    send_sample(16'sd32766);
    drain_pipeline();

    // Unsorted points with a repeat: spans of zero and below.
    set_curve(3'd6, 1'b0, 16'sd100, -16'sd100, 16'sd500, 16'sd500, 16'sh7fff, 16'sh8000);
    program_curve();
    send_sample(16'sd0);
    send_sample(16'sd200);
    send_sample(16'sd500);
    send_sample(16'sd600);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    drain_pipeline();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_random_curve();
      program_curve();
      gaps_on = (phase != 3);
      stall_on = (phase != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ((phase == 5 || phase == 11) && n == 10) hold_off = 1'b1;
        send_sample(pick_source());
      end
      drain_pipeline();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tcm_pkg.sv
rtl/tcm_select.sv
rtl/tcm_div_stage.sv
rtl/tcm_interp.sv
rtl/terrace_curve_mapper_unit.sv
tb/terrace_map_checker.sv
tb/tb.sv
